### rtl/aet_pkg.sv
// Shared constants and types for the adjacency edge table.
package aet_pkg;

   // Default sizing of the table
   localparam int MAX_EDGES_DEF      = 16;
   localparam int VERTEX_ID_BITS_DEF = 8;

   // Field widths of the request and response beats
   localparam int COMMAND_W      = 2;
   localparam int TARGET_W       = 8;
   localparam int WEIGHT_W       = 32;
   localparam int STATUS_W       = 3;
   localparam int EDGE_COUNT_W   = 5;

   // Bit offsets inside req_tdata
   localparam int REQ_CMD_LSB    = 0;
   localparam int REQ_TGT_LSB    = REQ_CMD_LSB + COMMAND_W;
   localparam int REQ_WGT_LSB    = REQ_TGT_LSB + TARGET_W;
   localparam int REQ_USED_W     = REQ_WGT_LSB + WEIGHT_W;
   localparam int REQ_TDATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   localparam int RSP_USED_W     = STATUS_W + WEIGHT_W + EDGE_COUNT_W;
   localparam int RSP_TDATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   // Command codes
   localparam logic [COMMAND_W-1:0] CMD_CONNECT = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_REMOVE  = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_LOOKUP  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

   // Sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_COMMIT
   } seq_state_type;

endpackage

### rtl/aet_store.sv
// Edge storage: destination id and weight per slot, one write and one registered read port.
module aet_store #(
   parameter int  DEPTH     = aet_pkg::MAX_EDGES_DEF,
   parameter int  ID_BITS   = aet_pkg::VERTEX_ID_BITS_DEF,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_BITS-1:0]         wr_addr,
   input  logic [ID_BITS-1:0]           wr_id,
   input  logic [aet_pkg::WEIGHT_W-1:0] wr_weight,
   input  logic [ADDR_BITS-1:0]         rd_addr,
   output logic [ID_BITS-1:0]           rd_id,
   output logic [aet_pkg::WEIGHT_W-1:0] rd_weight
);
   import aet_pkg::*;

   logic [WEIGHT_W+ID_BITS-1:0] mem [DEPTH];
   logic [WEIGHT_W+ID_BITS-1:0] rd_word_ff;

   // Write a whole slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_weight, wr_id};
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_word_ff <= mem[rd_addr];
   end

   assign rd_id     = rd_word_ff[ID_BITS-1:0];
   assign rd_weight = rd_word_ff[WEIGHT_W+ID_BITS-1:ID_BITS];

endmodule

### rtl/adjacency_edge_table.sv
// A beat is taken only in idle and is not followed by another until its commit; the
//   slot sweep between them compares one stored id per cycle through the single read
//   port, and commit waits while the output register still holds an untaken response.
// Reset (synchronous, active high) clears all valid bits, the edge count and the
//   sequencer; stored ids and weights are left as they are and never read unless valid.
// A finished response waits in the output register while the next beat is taken.
module adjacency_edge_table #(
   parameter int MAX_EDGES      = aet_pkg::MAX_EDGES_DEF,
   parameter int VERTEX_ID_BITS = aet_pkg::VERTEX_ID_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: command[1:0], target_vertex[9:2], edge_weight[41:10], zero fill
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [aet_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: status[2:0], found_weight[34:3], edge_count[39:35]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [aet_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import aet_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_EDGES);
   localparam int CNT_BITS = $clog2(MAX_EDGES + 1);

   seq_state_type state_ff, state_in;

   logic [COMMAND_W-1:0]      cmd_ff, cmd_in;
   logic [VERTEX_ID_BITS-1:0] id_ff, id_in;
   logic [WEIGHT_W-1:0]       weight_ff, weight_in;

   logic [IDX_BITS:0]         issue_ff, issue_in;
   logic                      cmp_on_ff, cmp_on_in;
   logic [IDX_BITS-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                      hit_ff, hit_in;
   logic [IDX_BITS-1:0]       hit_idx_ff, hit_idx_in;
   logic [WEIGHT_W-1:0]       hit_weight_ff, hit_weight_in;
   logic                      free_ok_ff, free_ok_in;
   logic [IDX_BITS-1:0]       free_idx_ff, free_idx_in;

   logic [MAX_EDGES-1:0]      valid_ff, valid_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [WEIGHT_W-1:0]       rsp_weight_ff, rsp_weight_in;
   logic [EDGE_COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                      wr_en;
   logic [IDX_BITS-1:0]       wr_addr;
   logic [VERTEX_ID_BITS-1:0] rd_id;
   logic [WEIGHT_W-1:0]       rd_weight;
   logic                      out_free;

   // Slot storage
   aet_store #(
      .DEPTH   (MAX_EDGES),
      .ID_BITS (VERTEX_ID_BITS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_id     (id_ff),
      .wr_weight (weight_ff),
      .rd_addr   (issue_ff[IDX_BITS-1:0]),
      .rd_id     (rd_id),
      .rd_weight (rd_weight)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         issue_ff     <= '0;
         cmp_on_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         free_ok_ff   <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         cmp_on_ff    <= cmp_on_in;
         hit_ff       <= hit_in;
         free_ok_ff   <= free_ok_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      weight_ff     <= weight_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_weight_ff <= hit_weight_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer: take a beat, sweep the slots, commit and post the response
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      weight_in     = weight_ff;
      issue_in      = issue_ff;
      cmp_on_in     = cmp_on_ff;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_weight_in = hit_weight_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_count_in  = rsp_count_ff;
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = free_idx_ff;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         SEQ_IDLE: begin
            // Hold off beats while reset is applied
            req_tready = !reset;
            if (req_tvalid) begin
               cmd_in     = req_tdata[REQ_CMD_LSB +: COMMAND_W];
               id_in      = VERTEX_ID_BITS'(req_tdata[REQ_TGT_LSB +: TARGET_W]);
               weight_in  = req_tdata[REQ_WGT_LSB +: WEIGHT_W];
               issue_in   = '0;
               cmp_on_in  = 1'b0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               state_in   = SEQ_SCAN;
            end
         end

         SEQ_SCAN: begin
            // Advance the read address until every slot has been issued
            if (issue_ff != (IDX_BITS + 1)'(MAX_EDGES)) begin
               issue_in   = issue_ff + (IDX_BITS + 1)'(1);
               cmp_on_in  = 1'b1;
               cmp_idx_in = issue_ff[IDX_BITS-1:0];
            end else begin
               cmp_on_in  = 1'b0;
               state_in   = SEQ_COMMIT;
            end
            // Compare the slot read last cycle; note the first free slot too
            if (cmp_on_ff) begin
               if (valid_ff[cmp_idx_ff] && (rd_id == id_ff) && !hit_ff) begin
                  hit_in        = 1'b1;
                  hit_idx_in    = cmp_idx_ff;
                  hit_weight_in = rd_weight;
               end
               if (!valid_ff[cmp_idx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
            end
         end

         SEQ_COMMIT: begin
            // Hold until the output register can take the result
            if (out_free) begin
               rsp_status_in = ST_NOT_FOUND;
               rsp_weight_in = '0;
               case (cmd_ff)
                  CMD_CONNECT: begin
                     if (hit_ff) begin
                        wr_en         = 1'b1;
                        wr_addr       = hit_idx_ff;
                        rsp_status_in = ST_UPDATED;
                     end else if (free_ok_ff) begin
                        wr_en                 = 1'b1;
                        wr_addr               = free_idx_ff;
                        valid_in[free_idx_ff] = 1'b1;
                        count_in              = count_ff + CNT_BITS'(1);
                        rsp_status_in         = ST_CREATED;
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  CMD_REMOVE: begin
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                        count_in             = count_ff - CNT_BITS'(1);
                        rsp_status_in        = ST_REMOVED;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (hit_ff) begin
                        rsp_weight_in = hit_weight_ff;
                        rsp_status_in = ST_FOUND;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               endcase
               rsp_count_in = EDGE_COUNT_W'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_count_ff, rsp_weight_ff, rsp_status_ff});

`ifndef NO_ASSERTIONS
   // Edge count tracks the number of valid slots
   a_count_matches : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(count_ff))
      else $error("edge count differs from valid slot total");

   // Count never exceeds the table size
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_EDGES)
      else $error("edge count above table size");

   // A new response only follows a commit
   a_rsp_from_commit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == SEQ_COMMIT)
      else $error("response posted outside commit");

   // Commit is reached only through a sweep
   a_commit_after_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_COMMIT) |-> ($past(state_ff) == SEQ_SCAN ||
                                    $past(state_ff) == SEQ_COMMIT))
      else $error("commit entered without a sweep");

   // Storage is written only during commit with the output register free
   a_write_in_commit : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == SEQ_COMMIT) && out_free)
      else $error("slot written outside commit");
`endif

endmodule
